>>> hw/rtl/vfcm_pkg.sv
// vfcm_pkg: shared types and constants of the voxel face cull mesher
// no dependencies; used by the top level and the port checker

package vfcm_pkg;

  localparam int COORD_W   = 5;
  localparam int DIR_W     = 3;
  localparam int CNT_W     = 18;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_DIRS  = 6;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MESH  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } vfcm_state_e;

endpackage

>>> hw/rtl/vfcm_ram.sv
// vfcm_ram: generic single-write, single-read ram with registered read data
// no dependencies

module vfcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/voxel_face_cull_mesher.sv
// Culled-face voxel mesher. The occupancy grid (MAX_DIM^3 bits) lives in one ram
// with a single read port and registered read data. A write request does not
// stall the input. A mesh request keeps the input stalled while the voxel and
// its six neighbors are read one per cycle through that port, then while each
// exposed face (0 to 6) is emitted, one at a time while the output is not stalled; an
// empty or fully covered voxel returns to idle after the reads. The grid is not
// cleared at reset: voxels must be written before they are meshed. Requests
// outside the configured sizes are dropped without effect.

module voxel_face_cull_mesher #(
  parameter int MAX_DIM = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [vfcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vfcm_pkg::CFG_W-1:0]       cfg_wdata_i,
  // requests
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [vfcm_pkg::COORD_W-1:0]     pos_x_i,
  input  logic [vfcm_pkg::COORD_W-1:0]     pos_y_i,
  input  logic [vfcm_pkg::COORD_W-1:0]     pos_z_i,
  input  logic                             occupied_i,
  input  logic                             first_of_pass_i,
  // faces
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [vfcm_pkg::COORD_W-1:0]     face_x_o,
  output logic [vfcm_pkg::COORD_W-1:0]     face_y_o,
  output logic [vfcm_pkg::COORD_W-1:0]     face_z_o,
  output logic [vfcm_pkg::DIR_W-1:0]       face_dir_o,
  output logic [vfcm_pkg::CNT_W-1:0]       face_number_o,
  output logic                             last_face_o
);

  import vfcm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_SQ = MAX_DIM * MAX_DIM;
  localparam int EXT_W  = CFG_W + 1;
  localparam int NC_W   = COORD_W + 1;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [NC_W-1:0] x, logic [NC_W-1:0] y,
                                                   logic [NC_W-1:0] z);
    return ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(MAX_DIM) + ADDR_W'(z) * ADDR_W'(DIM_SQ);
  endfunction

  // configuration registers
  logic [CFG_W-1:0] size_x_q, size_y_q, size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_X: size_x_q <= cfg_wdata_i;
        REG_SIZE_Y: size_y_q <= cfg_wdata_i;
        REG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // extents limited to MAX_DIM
  logic [EXT_W-1:0] ext_x, ext_y, ext_z;
  assign ext_x = ({1'b0, size_x_q} > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : {1'b0, size_x_q};
  assign ext_y = ({1'b0, size_y_q} > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : {1'b0, size_y_q};
  assign ext_z = ({1'b0, size_z_q} > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : {1'b0, size_z_q};

  logic in_fire, in_range, mesh_start;
  logic [NUM_DIRS-1:0] bnd_in;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign in_range = (EXT_W'(pos_x_i) < ext_x) && (EXT_W'(pos_y_i) < ext_y) &&
                    (EXT_W'(pos_z_i) < ext_z);
  assign mesh_start = in_fire && in_range && (req_type_i == REQ_MESH);

  // edge faces, in emission order -z +z -y +y -x +x
  assign bnd_in[0] = (pos_z_i == '0);
  assign bnd_in[1] = (EXT_W'(pos_z_i) + EXT_W'(1)) >= ext_z;
  assign bnd_in[2] = (pos_y_i == '0);
  assign bnd_in[3] = (EXT_W'(pos_y_i) + EXT_W'(1)) >= ext_y;
  assign bnd_in[4] = (pos_x_i == '0);
  assign bnd_in[5] = (EXT_W'(pos_x_i) + EXT_W'(1)) >= ext_x;

  // request registers
  logic [COORD_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [NUM_DIRS-1:0] bnd_q;

  always_ff @(posedge clk_i) begin
    if (mesh_start) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      bnd_q   <= bnd_in;
    end
  end

  // state
  vfcm_state_e state_q, state_d;
  logic [2:0]          rd_idx_q;
  logic [NUM_DIRS-1:0] mask_q, mask_d;
  logic [NUM_DIRS:0]   occ_q, occ_full;
  logic                rd_data;
  logic                load_face, last_pick;
  logic [DIR_W-1:0]    pick_idx;
  logic [NUM_DIRS-1:0] pick_oh;

  // read address: slot 0 is the voxel, slots 1 to 6 the neighbors
  logic [NC_W-1:0]  nx, ny, nz;
  logic [2:0]       dir_sel;
  logic [ADDR_W-1:0] raddr;

  assign dir_sel = rd_idx_q - 3'd1;

  always_comb begin
    nx = NC_W'(pos_x_q);
    ny = NC_W'(pos_y_q);
    nz = NC_W'(pos_z_q);
    // off-grid neighbors just reread the voxel; their bit is masked later
    if (rd_idx_q != 3'd0 && rd_idx_q != 3'd7 && !bnd_q[dir_sel]) begin
      case (rd_idx_q)
        3'd1:    nz = nz - NC_W'(1);
        3'd2:    nz = nz + NC_W'(1);
        3'd3:    ny = ny - NC_W'(1);
        3'd4:    ny = ny + NC_W'(1);
        3'd5:    nx = nx - NC_W'(1);
        3'd6:    nx = nx + NC_W'(1);
        default: ;
      endcase
    end
    raddr = cell_addr(nx, ny, nz);
  end

  vfcm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_vfcm_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && in_range && (req_type_i == REQ_WRITE)),
    .waddr_i (cell_addr(NC_W'(pos_x_i), NC_W'(pos_y_i), NC_W'(pos_z_i))),
    .wdata_i (occupied_i),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    occ_full = occ_q;
    occ_full[NUM_DIRS] = rd_data;
    mask_d = occ_full[0] ? (bnd_q | ~occ_full[NUM_DIRS:1]) : '0;
  end

  // lowest pending direction goes first
  always_comb begin
    pick_idx = '0;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        pick_idx = DIR_W'(i);
      end
    end
    pick_oh   = NUM_DIRS'(1) << pick_idx;
    last_pick = (mask_q & ~pick_oh) == '0;
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    load_face = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (mesh_start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_idx_q == 3'd7) begin
          state_d = (mask_d != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        load_face = !out_valid_q || !out_stall_i;
        if (load_face && last_pick) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      mask_q   <= '0;
    end else begin
      if (state_q == ST_READ) begin
        rd_idx_q <= rd_idx_q + 3'd1;
      end else begin
        rd_idx_q <= '0;
      end
      if (state_q == ST_READ && rd_idx_q == 3'd7) begin
        mask_q <= mask_d;
      end else if (load_face) begin
        mask_q <= mask_q & ~pick_oh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ && rd_idx_q != 3'd0) begin
      occ_q[dir_sel] <= rd_data;
    end
  end

  // face counter
  logic [CNT_W-1:0] face_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_cnt_q <= '0;
    end else if (mesh_start && first_of_pass_i) begin
      face_cnt_q <= '0;
    end else if (load_face) begin
      face_cnt_q <= face_cnt_q + CNT_W'(1);
    end
  end

  // output register
  logic [COORD_W-1:0] face_x_q, face_y_q, face_z_q;
  logic [DIR_W-1:0]   face_dir_q;
  logic [CNT_W-1:0]   face_number_q;
  logic               last_face_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_face || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_face) begin
      face_x_q      <= pos_x_q;
      face_y_q      <= pos_y_q;
      face_z_q      <= pos_z_q;
      face_dir_q    <= pick_idx;
      face_number_q <= face_cnt_q;
      last_face_q   <= last_pick;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign face_x_o      = face_x_q;
  assign face_y_o      = face_y_q;
  assign face_z_o      = face_z_q;
  assign face_dir_o    = face_dir_q;
  assign face_number_o = face_number_q;
  assign last_face_o   = last_face_q;

endmodule

>>> hw/rtl/vfcm_checker.sv
// vfcm_checker: port-level assertions for the voxel face cull mesher
// depends on vfcm_pkg; bound to voxel_face_cull_mesher below

module vfcm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [vfcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [vfcm_pkg::CFG_W-1:0]       cfg_wdata_i,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             req_type_i,
  input logic [vfcm_pkg::COORD_W-1:0]     pos_x_i,
  input logic [vfcm_pkg::COORD_W-1:0]     pos_y_i,
  input logic [vfcm_pkg::COORD_W-1:0]     pos_z_i,
  input logic                             occupied_i,
  input logic                             first_of_pass_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [vfcm_pkg::COORD_W-1:0]     face_x_o,
  input logic [vfcm_pkg::COORD_W-1:0]     face_y_o,
  input logic [vfcm_pkg::COORD_W-1:0]     face_z_o,
  input logic [vfcm_pkg::DIR_W-1:0]       face_dir_o,
  input logic [vfcm_pkg::CNT_W-1:0]       face_number_o,
  input logic                             last_face_o
);

  import vfcm_pkg::*;

  // a stalled face holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(face_dir_o) &&
    $stable(face_number_o) && $stable(last_face_o))
    else $error("stalled face changed");

  // the block only goes busy after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("busy without an accepted item");

  // more faces pending means the request is still being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_face_o |-> in_stall_o)
    else $error("input free while faces of a request remain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> face_dir_o < DIR_W'(NUM_DIRS))
    else $error("face direction out of range");

endmodule

bind voxel_face_cull_mesher vfcm_checker u_vfcm_checker (.*);
